>>> hw/rtl/mdpu_pkg.sv
package mdpu_pkg;

    localparam logic [31:0] QNAN = 32'h7FC0_0000;
    localparam logic [7:0] EXP_MAX = 8'hFF;

    typedef enum logic
    {
        REG_WEIGHT_FORMAT = 1'b0,
        REG_BIAS_ENABLE = 1'b1
    } reg_index_t;

    typedef struct packed
    {
        logic valid;
        logic last;
    } stage_ctl_t;

    function automatic logic [31:0] half_to_single(input logic [15:0] h);
        logic [4:0] ex;
        logic [9:0] fr;
        logic [10:0] fs;
        logic [3:0] k;
        ex = h[14:10];
        fr = h[9:0];
        k = 4'd0;
        for (int i = 0; i < 10; i++)
        begin
            if (fr[i])
            begin
                k = 4'(10 - i);
            end
        end
        fs = {1'b0, fr} << k;
        if (ex == 5'h1F)
        begin
            return {h[15], EXP_MAX, fr, 13'h0};
        end
        else if (ex != 5'h0)
        begin
            return {h[15], 8'({3'b0, ex} + 8'd112), fr, 13'h0};
        end
        else if (fr == 10'h0)
        begin
            return {h[15], 31'h0};
        end
        else
        begin
            return {h[15], 8'(8'd113 - {4'b0, k}), fs[9:0], 13'h0};
        end
    endfunction

    function automatic logic [5:0] lzc48(input logic [47:0] v);
        logic [5:0] n;
        n = 6'd0;
        for (int i = 0; i < 48; i++)
        begin
            if (v[i])
            begin
                n = 6'(47 - i);
            end
        end
        return n;
    endfunction

    function automatic logic [5:0] lzc51(input logic [50:0] v);
        logic [5:0] n;
        n = 6'd0;
        for (int i = 0; i < 51; i++)
        begin
            if (v[i])
            begin
                n = 6'(50 - i);
            end
        end
        return n;
    endfunction

    // The significand has its leading one at bit 47; be is the biased exponent.
    function automatic logic [31:0] round_pack(input logic sgn, input logic signed [11:0] be,
                                               input logic [47:0] sig);
        logic [47:0] s;
        logic st;
        logic [11:0] sh;
        logic [7:0] ef;
        logic rup;
        logic [30:0] r;
        s = sig;
        st = 1'b0;
        ef = be[7:0];
        sh = 12'd0;
        if (be >= 12'sd255)
        begin
            return {sgn, EXP_MAX, 23'h0};
        end
        if (be <= 12'sd0)
        begin
            sh = 12'(12'sd1 - be);
            if (sh > 12'd48)
            begin
                sh = 12'd48;
            end
            for (int i = 0; i < 48; i++)
            begin
                if (12'(i) < sh)
                begin
                    st = st | sig[i];
                end
            end
            s = sig >> sh;
            ef = 8'h0;
        end
        st = st | (|s[22:0]);
        rup = s[23] & (st | s[24]);
        r = {ef, s[46:24]} + {30'h0, rup};
        return {sgn, r};
    endfunction

    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        logic na, nb, ia, ib, za, zb, s;
        logic [23:0] ma, mb;
        logic [7:0] xa, xb;
        logic [47:0] p;
        logic [5:0] lz;
        logic signed [11:0] be;
        na = (a[30:23] == EXP_MAX) && (a[22:0] != 23'h0);
        nb = (b[30:23] == EXP_MAX) && (b[22:0] != 23'h0);
        ia = (a[30:23] == EXP_MAX) && (a[22:0] == 23'h0);
        ib = (b[30:23] == EXP_MAX) && (b[22:0] == 23'h0);
        za = a[30:0] == 31'h0;
        zb = b[30:0] == 31'h0;
        s = a[31] ^ b[31];
        ma = {a[30:23] != 8'h0, a[22:0]};
        mb = {b[30:23] != 8'h0, b[22:0]};
        xa = (a[30:23] == 8'h0) ? 8'h1 : a[30:23];
        xb = (b[30:23] == 8'h0) ? 8'h1 : b[30:23];
        p = ma * mb;
        lz = lzc48(p);
        be = $signed({4'b0, xa}) + $signed({4'b0, xb}) - 12'sd126 - $signed({6'b0, lz});
        if (na || nb || (ia && zb) || (za && ib))
        begin
            return QNAN;
        end
        else if (ia || ib)
        begin
            return {s, EXP_MAX, 23'h0};
        end
        else if (za || zb)
        begin
            return {s, 31'h0};
        end
        else
        begin
            return round_pack(s, be, p << lz);
        end
    endfunction

    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] x, y;
        logic nx, ny, ix, iy;
        logic [23:0] mx, my;
        logic [7:0] ex, ey, d;
        logic [49:0] bx, by0, by;
        logic st;
        logic [50:0] sum, sn;
        logic [5:0] lz;
        logic signed [11:0] be;
        nx = (a[30:23] == EXP_MAX) && (a[22:0] != 23'h0);
        ny = (b[30:23] == EXP_MAX) && (b[22:0] != 23'h0);
        ix = (a[30:23] == EXP_MAX) && (a[22:0] == 23'h0);
        iy = (b[30:23] == EXP_MAX) && (b[22:0] == 23'h0);
        if (a[30:0] < b[30:0])
        begin
            x = b;
            y = a;
        end
        else
        begin
            x = a;
            y = b;
        end
        mx = {x[30:23] != 8'h0, x[22:0]};
        my = {y[30:23] != 8'h0, y[22:0]};
        ex = (x[30:23] == 8'h0) ? 8'h1 : x[30:23];
        ey = (y[30:23] == 8'h0) ? 8'h1 : y[30:23];
        d = ex - ey;
        bx = {mx, 26'h0};
        by0 = {my, 26'h0};
        by = by0 >> d;
        st = |(by0 & ~({50{1'b1}} << d));
        by[0] = by[0] | st;
        if (x[31] == y[31])
        begin
            sum = {1'b0, bx} + {1'b0, by};
        end
        else
        begin
            sum = {1'b0, bx} - {1'b0, by};
        end
        lz = lzc51(sum);
        sn = sum << lz;
        be = $signed({4'b0, ex}) + 12'sd1 - $signed({6'b0, lz});
        if (nx || ny || (ix && iy && (a[31] != b[31])))
        begin
            return QNAN;
        end
        else if (ix)
        begin
            return a;
        end
        else if (iy)
        begin
            return b;
        end
        else if (sum == 51'h0)
        begin
            return {a[31] & b[31], 31'h0};
        end
        else
        begin
            return round_pack(x[31], be, {sn[50:4], |sn[3:0]});
        end
    endfunction

endpackage

>>> hw/rtl/mdpu_mul.sv
module mdpu_mul
    import mdpu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  stage_ctl_t  ctl_in,
    input  logic [31:0] act,
    input  logic [31:0] wgt,
    input  logic [31:0] bias_in,
    output stage_ctl_t  ctl_out,
    output logic [31:0] prod,
    output logic [31:0] bias_out
);

    stage_ctl_t ctl_reg;
    logic [31:0] prod_reg;
    logic [31:0] bias_reg;
    logic [31:0] prod_next;

    assign prod_next = fp_mul(act, wgt);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (adv)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= prod_next;
            bias_reg <= bias_in;
        end
    end

    assign ctl_out = ctl_reg;
    assign prod = prod_reg;
    assign bias_out = bias_reg;

endmodule

>>> hw/rtl/mdpu_acc.sv
module mdpu_acc
    import mdpu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  stage_ctl_t  ctl_in,
    input  logic [31:0] prod,
    input  logic [31:0] bias_in,
    output logic        fin_valid,
    output logic [31:0] fin_sum,
    output logic [31:0] bias_out
);

    logic [31:0] sum_reg;
    logic [31:0] sum_next;
    logic        fin_valid_reg;
    logic [31:0] fin_sum_reg;
    logic [31:0] bias_reg;

    assign sum_next = fp_add(sum_reg, prod);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= 32'h0;
            fin_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            fin_valid_reg <= ctl_in.valid & ctl_in.last;
            if (ctl_in.valid)
            begin
                sum_reg <= ctl_in.last ? 32'h0 : sum_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fin_sum_reg <= sum_next;
            bias_reg <= bias_in;
        end
    end

    assign fin_valid = fin_valid_reg;
    assign fin_sum = fin_sum_reg;
    assign bias_out = bias_reg;

endmodule

>>> hw/rtl/mdpu_fin.sv
module mdpu_fin
    import mdpu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  logic        bias_enable,
    input  logic        fin_valid,
    input  logic [31:0] fin_sum,
    input  logic [31:0] bias_in,
    output logic        res_valid,
    output logic [31:0] res
);

    logic        valid_reg;
    logic [31:0] res_reg;
    logic [31:0] res_next;

    assign res_next = fp_add(bias_enable ? bias_in : 32'h0, fin_sum);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= fin_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && fin_valid)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = valid_reg;
    assign res = res_reg;

endmodule

>>> hw/rtl/mixed_precision_dot_product_unit.sv
// A row result goes through the input, multiply, accumulate and final registers.
// One input transaction per cycle while not stalled; the accumulate adder sets the rate.
// The whole pipeline holds while a result waits under out_stall.
// Reset (rst_n low, asynchronous) clears the sum to +0, both registers to 0
// and all valid flags.
module mixed_precision_dot_product_unit
    import mdpu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] activation,
    input  logic [31:0] weight_bits,
    input  logic [31:0] bias_value,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] dot_result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic        cfg_data
);

    logic        adv;
    logic        weight_format_reg;
    logic        bias_enable_reg;
    stage_ctl_t  in_ctl_reg;
    logic [31:0] act_reg;
    logic [31:0] wgt_reg;
    logic [31:0] bias_reg;
    stage_ctl_t  in_ctl_next;
    logic [31:0] wgt_next;
    stage_ctl_t  mul_ctl;
    logic [31:0] mul_prod;
    logic [31:0] mul_bias;
    logic        fin_valid;
    logic [31:0] fin_sum;
    logic [31:0] fin_bias;

    assign adv = !(out_valid && out_stall);
    assign in_stall = !adv;
    assign cfg_ready = 1'b1;

    assign in_ctl_next = '{valid: in_valid, last: last};
    assign wgt_next = weight_format_reg ? half_to_single(weight_bits[15:0]) : weight_bits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_format_reg <= 1'b0;
            bias_enable_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_WEIGHT_FORMAT: weight_format_reg <= cfg_data;
                REG_BIAS_ENABLE:   bias_enable_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ctl_reg <= '0;
        end
        else if (adv)
        begin
            in_ctl_reg <= in_ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            act_reg <= activation;
            wgt_reg <= wgt_next;
            bias_reg <= bias_value;
        end
    end

    mdpu_mul u_mul
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .ctl_in   (in_ctl_reg),
        .act      (act_reg),
        .wgt      (wgt_reg),
        .bias_in  (bias_reg),
        .ctl_out  (mul_ctl),
        .prod     (mul_prod),
        .bias_out (mul_bias)
    );

    mdpu_acc u_acc
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .ctl_in    (mul_ctl),
        .prod      (mul_prod),
        .bias_in   (mul_bias),
        .fin_valid (fin_valid),
        .fin_sum   (fin_sum),
        .bias_out  (fin_bias)
    );

    mdpu_fin u_fin
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .bias_enable (bias_enable_reg),
        .fin_valid   (fin_valid),
        .fin_sum     (fin_sum),
        .bias_in     (fin_bias),
        .res_valid   (out_valid),
        .res         (dot_result)
    );

endmodule

>>> hw/rtl/mdpu_checker.sv
module mdpu_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] dot_result,
    input logic        cfg_ready
);

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(dot_result))
        else $error("Stalled result transaction changed.");

    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("Input stall does not follow the output side.");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("Configuration port not ready.");

    a_canon_nan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (dot_result[30:23] == 8'hFF) && (dot_result[22:0] != 23'h0)
        |-> dot_result == 32'h7FC0_0000)
        else $error("NaN result is not canonical.");

endmodule

bind mixed_precision_dot_product_unit mdpu_checker u_mdpu_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .dot_result (dot_result),
    .cfg_ready  (cfg_ready)
);

>>> dv/mixed_precision_dot_product_unit_checker.sv
module mixed_precision_dot_product_unit_checker
    import mdpu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [31:0] activation,
    input  logic [31:0] weight_bits,
    input  logic [31:0] bias_value,
    input  logic        last,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [31:0] dot_result,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_index,
    input  logic        cfg_data,
    output int          errors,
    output int          pending,
    output int          elements_seen,
    output int          sums_seen
);

    logic [31:0] expected_sums[$];
    logic        fmt_half;
    logic        add_bias;
    logic [31:0] partial_sum;

    function automatic logic [31:0] widen_half(input logic [15:0] h);
        logic [10:0] m;
        logic [7:0] be;
        m = {1'b0, h[9:0]};
        be = 8'd113;
        if (h[14:10] == 5'h1F)
        begin
            return {h[15], 8'hFF, h[9:0], 13'h0};
        end
        if (h[14:10] != 5'h0)
        begin
            return {h[15], 8'(h[14:10] + 8'd112), h[9:0], 13'h0};
        end
        if (h[9:0] == 10'h0)
        begin
            return {h[15], 31'h0};
        end
        while (!m[10])
        begin
            m = m << 1;
            be = be - 8'd1;
        end
        return {h[15], be, m[9:0], 13'h0};
    endfunction

    function automatic real single_to_real(input logic [31:0] b);
        logic [23:0] m;
        int ex;
        if (b[30:23] == 8'hFF)
        begin
            if (b[22:0] != 23'h0)
            begin
                return $bitstoreal({b[31], 63'h7FF8_0000_0000_0000});
            end
            return $bitstoreal({b[31], 63'h7FF0_0000_0000_0000});
        end
        if (b[30:0] == 31'h0)
        begin
            return $bitstoreal({b[31], 63'h0});
        end
        m = {b[30:23] != 8'h0, b[22:0]};
        ex = (b[30:23] == 8'h0) ? -126 : int'(b[30:23]) - 127;
        while (!m[23])
        begin
            m = m << 1;
            ex = ex - 1;
        end
        return $bitstoreal({b[31], 11'(ex + 1023), m[22:0], 29'h0});
    endfunction

    // Rounding a double to single is exact enough here: the double holds
    // products exactly, and double rounding of a sum of two singles is harmless.
    function automatic logic [31:0] real_to_single(input real r);
        logic [63:0] d;
        logic [63:0] sig, kept, rest, halfway, packed_bits;
        int be, sh;
        logic rup;
        d = $realtobits(r);
        if (d[62:52] == 11'h7FF)
        begin
            return (d[51:0] != 52'h0) ? QNAN : {d[63], 31'h7F80_0000};
        end
        if (d[62:0] == 63'h0)
        begin
            return {d[63], 31'h0};
        end
        sig = {11'h0, 1'b1, d[51:0]};
        be = int'(d[62:52]) - 1023 + 127;
        if (be >= 255)
        begin
            return {d[63], 31'h7F80_0000};
        end
        sh = (be >= 1) ? 29 : 30 - be;
        if (sh > 60)
        begin
            sh = 60;
        end
        kept = sig >> sh;
        rest = sig & ((64'h1 << sh) - 64'h1);
        halfway = 64'h1 << (sh - 1);
        rup = (rest > halfway) || ((rest == halfway) && kept[0]);
        packed_bits = ((be >= 1) ? (64'(be) << 23) : 64'h0) | (kept & 64'h7F_FFFF);
        packed_bits = packed_bits + 64'(rup);
        return {d[63], packed_bits[30:0]};
    endfunction

    function automatic logic [31:0] add_single(input logic [31:0] a, input logic [31:0] b);
        return real_to_single(single_to_real(a) + single_to_real(b));
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [31:0] w, prod, total;
        if (!rst_n)
        begin
            expected_sums.delete();
            fmt_half <= 1'b0;
            add_bias <= 1'b0;
            partial_sum <= 32'h0;
            errors <= 0;
            elements_seen <= 0;
            sums_seen <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (reg_index_t'(cfg_index) == REG_WEIGHT_FORMAT)
                begin
                    fmt_half <= cfg_data;
                end
                else if (reg_index_t'(cfg_index) == REG_BIAS_ENABLE)
                begin
                    add_bias <= cfg_data;
                end
            end
            if (in_valid && !in_stall)
            begin
                w = fmt_half ? widen_half(weight_bits[15:0]) : weight_bits;
                prod = real_to_single(single_to_real(activation) * single_to_real(w));
                total = add_single(partial_sum, prod);
                elements_seen <= elements_seen + 1;
                if (last)
                begin
                    total = add_single(add_bias ? bias_value : 32'h0, total);
                    if (total[30:23] == 8'hFF && total[22:0] != 23'h0)
                    begin
                        total = QNAN;
                    end
                    expected_sums.push_back(total);
                    partial_sum <= 32'h0;
                end
                else
                begin
                    partial_sum <= total;
                end
            end
            if (out_valid && !out_stall)
            begin
                sums_seen <= sums_seen + 1;
                if (expected_sums.size() == 0)
                begin
                    if (errors < 10)
                    begin
                        $display("Unexpected result transaction: dot_result %h", dot_result);
                    end
                    errors <= errors + 1;
                end
                else
                begin
                    total = expected_sums.pop_front();
                    if (total !== dot_result)
                    begin
                        if (errors < 10)
                        begin
                            $display("Mismatch on dot_result: expected %h, got %h",
                                     total, dot_result);
                        end
                        errors <= errors + 1;
                    end
                end
            end
        end
    end

    assign pending = expected_sums.size();

endmodule

>>> dv/mixed_precision_dot_product_unit_test.sv
module mixed_precision_dot_product_unit_test;
    import mdpu_pkg::*;

    localparam int CYCLE_LIMIT = 300000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] activation;
    logic [31:0] weight_bits;
    logic [31:0] bias_value;
    logic        last;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] dot_result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic        cfg_data;
    int          errors;
    int          pending;
    int          elements_seen;
    int          sums_seen;
    int          cycles = 0;
    int          stall_left = 0;
    logic        busy_sender;

    mixed_precision_dot_product_unit dut (.*);

    mixed_precision_dot_product_unit_checker checker_inst (.*);

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        activation = 32'h0;
        weight_bits = 32'h0;
        bias_value = 32'h0;
        last = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = 1'b0;
        cfg_data = 1'b0;
        busy_sender = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Run timed out after %0d cycles.", cycles);
            $display("mixed_precision_dot_product_unit_test NOT OK");
            $finish;
        end
    end

    function automatic int pick_gap();
        if (busy_sender || $urandom_range(0, 9) < 6)
        begin
            return 0;
        end
        return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 30);
    endfunction

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 99) < 20)
        begin
            out_stall <= 1'b1;
            stall_left <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3)
                                                      : $urandom_range(10, 40);
        end
        else
        begin
            out_stall <= 1'b0;
            stall_left <= ($urandom_range(0, 9) < 2) ? $urandom_range(20, 60) : 0;
        end
    end

    task automatic write_register(input reg_index_t idx, input logic value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_element(input logic [31:0] a, input logic [31:0] w,
                                input logic [31:0] b, input logic l);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        activation <= a;
        weight_bits <= w;
        bias_value <= b;
        last <= l;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
    endtask

    task automatic drain_and_configure(input logic fmt, input logic bias);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
        write_register(REG_WEIGHT_FORMAT, fmt);
        write_register(REG_BIAS_ENABLE, bias);
    endtask

    function automatic logic [31:0] pick_single();
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return {1'($urandom()), 8'h0, 23'($urandom())};
            2:
            begin
                case ($urandom_range(0, 5))
                    0: return 32'h0000_0000;
                    1: return 32'h8000_0000;
                    2: return 32'h7F80_0000;
                    3: return 32'hFF80_0000;
                    4: return 32'h7F7F_FFFF;
                    default: return 32'h7FC0_0001;
                endcase
            end
            3: return {1'($urandom()), 8'($urandom_range(230, 254)), 23'($urandom())};
            4: return {1'($urandom()), 8'($urandom_range(1, 20)), 23'($urandom())};
            default: return {1'($urandom()), 8'($urandom_range(115, 135)), 23'($urandom())};
        endcase
    endfunction

    function automatic logic [31:0] pick_half_word();
        logic [15:0] h;
        case ($urandom_range(0, 7))
            0: h = 16'($urandom());
            1: h = {1'($urandom()), 5'h0, 10'($urandom())};
            2: h = {1'($urandom()), 5'h1F, ($urandom_range(0, 1) == 0) ? 10'h0 : 10'($urandom())};
            default: h = {1'($urandom()), 5'($urandom_range(10, 20)), 10'($urandom())};
        endcase
        return {16'($urandom()), h};
    endfunction

    task automatic send_random_rows(input logic fmt, input int count);
        int len;
        int sent;
        sent = 0;
        while (sent < count)
        begin
            len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 6) : $urandom_range(7, 16);
            for (int i = 0; i < len; i++)
            begin
                send_element(pick_single(), fmt ? pick_half_word() : pick_single(),
                             pick_single(), i == len - 1);
            end
            sent += len;
        end
    endtask

    initial
    begin
        @(posedge clk);
        while (!rst_n)
        begin
            @(posedge clk);
        end
        write_register(REG_WEIGHT_FORMAT, 1'b0);
        write_register(REG_BIAS_ENABLE, 1'b0);

        send_element(32'h3F80_0000, 32'h4000_0000, 32'h0, 1'b0);
        send_element(32'hBF80_0000, 32'h4000_0000, 32'h0, 1'b1);
        send_element(32'h8000_0000, 32'h3F80_0000, 32'h4120_0000, 1'b1);
        send_element(32'h7F80_0000, 32'h0000_0000, 32'h0, 1'b1);
        send_element(32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h0, 1'b1);
        send_element(32'h0000_0001, 32'h3F00_0000, 32'h0, 1'b1);
        send_element(32'h7F80_0000, 32'h3F80_0000, 32'h0, 1'b0);
        send_element(32'hFF80_0000, 32'h3F80_0000, 32'h0, 1'b1);
        send_element(32'hFFFF_FFFF, 32'h0000_0001, 32'h0, 1'b1);

        drain_and_configure(1'b1, 1'b1);
        send_element(32'h3F80_0000, 32'hFFFF_7C00, 32'h3F80_0000, 1'b1);
        send_element(32'h3F80_0000, 32'h0000_FC00, 32'h0, 1'b1);
        send_element(32'h3F80_0000, 32'hA5A5_7E01, 32'h0, 1'b1);
        send_element(32'h3F80_0000, 32'h1234_0001, 32'h8000_0000, 1'b1);
        send_element(32'h3F80_0000, 32'h0000_03FF, 32'h0, 1'b0);
        send_element(32'h4000_0000, 32'hFFFF_8000, 32'h0, 1'b0);
        send_element(32'hC000_0000, 32'h0000_7BFF, 32'h7F7F_FFFF, 1'b1);
        send_element(32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 1'b1);
        send_element(32'h3F80_0000, 32'h0000_3C00, 32'hFF80_0000, 1'b1);

        drain_and_configure(1'b0, 1'b1);
        send_random_rows(1'b0, 110);
        drain_and_configure(1'b1, 1'b0);
        send_random_rows(1'b1, 110);
        drain_and_configure(1'b1, 1'b1);
        busy_sender <= 1'b1;
        send_random_rows(1'b1, 60);
        busy_sender <= 1'b0;
        send_random_rows(1'b1, 50);
        drain_and_configure(1'b0, 1'b0);
        send_random_rows(1'b0, 100);
        in_valid <= 1'b0;

        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (12) @(posedge clk);
        $display("Covered %0d input elements and %0d row results over all four register settings,",
                 elements_seen, sums_seen);
        $display("with fp32 and fp16 weights, bias on and off, and random stalls on both sides.");
        if (errors == 0)
        begin
            $display("mixed_precision_dot_product_unit_test OK");
        end
        else
        begin
            $display("mixed_precision_dot_product_unit_test NOT OK");
        end
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/mdpu_pkg.sv
hw/rtl/mdpu_mul.sv
hw/rtl/mdpu_acc.sv
hw/rtl/mdpu_fin.sv
hw/rtl/mixed_precision_dot_product_unit.sv
hw/rtl/mdpu_checker.sv
dv/mixed_precision_dot_product_unit_checker.sv
dv/mixed_precision_dot_product_unit_test.sv
